// ===== src/cbi_pkg.sv =====
`timescale 1ns / 1ps
// cbi_pkg: shared types and constants of the comfort blink indicator controller
// no dependencies; used by cbi_step and the top level

package cbi_pkg;

    // run direction as shown on the result stream
    typedef enum logic [1:0] {
        HEAD_OFF   = 2'd0,
        HEAD_LEFT  = 2'd1,
        HEAD_RIGHT = 2'd2
    } heading_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_BLINKS     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_LENGTH   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF        = 2'd3;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned PULSE_W    = 16;

    // register reset values
    localparam logic [15:0]        RST_BLINK_INTERVAL = 16'd400;
    localparam logic [COUNT_W-1:0] RST_MAX_BLINKS     = 8'd3;
    localparam logic [PULSE_W-1:0] RST_PULSE_LENGTH   = 16'd300;
    localparam logic [15:0]        RST_HOLDOFF        = 16'd251;

    localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

    typedef struct packed {
        logic [15:0]        blink_interval;
        logic [COUNT_W-1:0] max_blinks;
        logic [PULSE_W-1:0] pulse_length;
        logic [15:0]        holdoff;
    } cfg_t;

    // run state except the elapsed timer, whose width is a parameter
    typedef struct packed {
        logic               active;
        heading_t           heading;
        logic [COUNT_W-1:0] blink_count;
        logic [PULSE_W-1:0] pulse_remaining;
    } run_state_t;

    // one result item
    typedef struct packed {
        logic               drive_left;
        logic               drive_right;
        logic               run_active;
        heading_t           run_direction;
        logic [COUNT_W-1:0] blinks_done;
    } result_t;

endpackage

// ===== src/comfort_blink_indicator_controller_unit.sv =====
`timescale 1ns / 1ps
// comfort_blink_indicator_controller_unit: top level with config registers,
// input and result registers; depends on cbi_pkg and cbi_step
//
// usage:
//   s_axis carries one millisecond tick per transfer with the stalk levels.
//   m_axis returns exactly one result per tick: drive lines, run status,
//   run direction and the blink count after that tick.
//   cfg_we/cfg_index/cfg_data write blink_interval (0), max_blinks (1),
//   pulse_length (2) and holdoff (3); write only while no tick is in flight.
// stages and throughput:
//   a tick is held in the input register, its result is computed by
//   cbi_step combinationally and lands in the result register when that
//   register is free or draining. one tick is accepted every cycle while
//   m_axis_tready is high; the state update in cbi_step is combinational.
// reset:
//   rst_n clears run state and both stage valids, and loads the register
//   defaults (400, 3, 300, 251).
// stall:
//   while m_axis_tready is low the result holds; one more tick is taken
//   into the input register, then s_axis_tready drops until the result moves.

module comfort_blink_indicator_controller_unit #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [0] left_level, [1] right_level
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,  // [0] drive_left, [1] drive_right,
                                                             // [2] run_active, [4:3] run_direction,
                                                             // [12:5] blinks_done
    // configuration writes
    input  logic                              cfg_we,
    input  logic [cbi_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cbi_pkg::CFG_DATA_W-1:0]    cfg_data
);

    cbi_pkg::cfg_t          cfg_reg;

    // input stage
    logic                   in_valid_reg;
    logic                   left_reg;
    logic                   right_reg;

    // run state
    cbi_pkg::run_state_t    state_reg;
    cbi_pkg::run_state_t    state_next;
    logic [TIMER_WIDTH-1:0] elapsed_reg;
    logic [TIMER_WIDTH-1:0] elapsed_next;

    // result stage
    logic                   out_valid_reg;
    cbi_pkg::result_t       result_reg;
    cbi_pkg::result_t       result_next;

    logic                   advance;
    logic                   take_in;

    // result register free or draining this cycle
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blink_interval <= cbi_pkg::RST_BLINK_INTERVAL;
            cfg_reg.max_blinks     <= cbi_pkg::RST_MAX_BLINKS;
            cfg_reg.pulse_length   <= cbi_pkg::RST_PULSE_LENGTH;
            cfg_reg.holdoff        <= cbi_pkg::RST_HOLDOFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cbi_pkg::REG_BLINK_INTERVAL: cfg_reg.blink_interval <= cfg_data;
                cbi_pkg::REG_MAX_BLINKS:
                    cfg_reg.max_blinks <= cfg_data[cbi_pkg::COUNT_W-1:0];
                cbi_pkg::REG_PULSE_LENGTH:   cfg_reg.pulse_length <= cfg_data;
                cbi_pkg::REG_HOLDOFF:        cfg_reg.holdoff <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register: valid bit reset, payload not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            left_reg  <= s_axis_tdata[0];
            right_reg <= s_axis_tdata[1];
        end
    end

    cbi_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .left_level   (left_reg),
        .right_level  (right_reg),
        .cfg          (cfg_reg),
        .state        (state_reg),
        .elapsed      (elapsed_reg),
        .state_next   (state_next),
        .elapsed_next (elapsed_next),
        .result       (result_next)
    );

    // state and result update once per processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.active          <= 1'b0;
            state_reg.heading         <= cbi_pkg::HEAD_OFF;
            state_reg.blink_count     <= '0;
            state_reg.pulse_remaining <= '0;
            elapsed_reg               <= '0;
            out_valid_reg             <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg   <= state_next;
                elapsed_reg <= elapsed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            result_reg <= result_next;
    end

    assign m_axis_tvalid        = out_valid_reg;
    assign m_axis_tdata[0]      = result_reg.drive_left;
    assign m_axis_tdata[1]      = result_reg.drive_right;
    assign m_axis_tdata[2]      = result_reg.run_active;
    assign m_axis_tdata[4:3]    = result_reg.run_direction;
    assign m_axis_tdata[12:5]   = result_reg.blinks_done;
    assign m_axis_tdata[15:13]  = 3'b000;

`ifndef NO_ASSERTIONS
    // both indicator lines are never driven on the same tick
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("both drive lines high");

    // a pulse only runs inside an active run
    a_pulse_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.pulse_remaining != '0) |-> state_reg.active)
        else $error("pulse without active run");

    // an idle run has no heading
    a_idle_off: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.active |-> (state_reg.heading == cbi_pkg::HEAD_OFF))
        else $error("heading set while idle");

    // a held tick moves into an empty result register next cycle
    a_move_on: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("tick not forwarded to result register");
`endif

endmodule

// ===== src/cbi_step.sv =====
`timescale 1ns / 1ps
// cbi_step: next-state and result logic for one tick
// depends on cbi_pkg

module cbi_step #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic                   left_level,
    input  logic                   right_level,
    input  cbi_pkg::cfg_t          cfg,
    input  cbi_pkg::run_state_t    state,
    input  logic [TIMER_WIDTH-1:0] elapsed,
    output cbi_pkg::run_state_t    state_next,
    output logic [TIMER_WIDTH-1:0] elapsed_next,
    output cbi_pkg::result_t       result
);

    localparam int unsigned CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [TIMER_WIDTH-1:0] TIMER_TOP = '1;

    logic                          any_level;
    cbi_pkg::heading_t             dir;
    logic                          drive;
    logic [cbi_pkg::PULSE_W-1:0]   plen;
    logic [cbi_pkg::PULSE_W-1:0]   prem_dec;
    logic [CMP_W-1:0]              el_x;
    logic [CMP_W-1:0]              holdoff_x;
    logic [CMP_W-1:0]              interval_x;
    cbi_pkg::run_state_t           s;
    logic [TIMER_WIDTH-1:0]        e;
    logic                          do_end_check;

    assign any_level  = left_level | right_level;
    assign dir        = left_level ? cbi_pkg::HEAD_LEFT : cbi_pkg::HEAD_RIGHT;
    assign plen       = (cfg.pulse_length != '0) ? cfg.pulse_length
                                                 : cbi_pkg::PULSE_W'(1);
    assign holdoff_x  = CMP_W'(cfg.holdoff);
    assign interval_x = CMP_W'(cfg.blink_interval);

    always_comb
    begin
        s            = state;
        e            = elapsed;
        drive        = 1'b0;
        prem_dec     = '0;
        el_x         = '0;
        do_end_check = 1'b0;

        if (state.pulse_remaining != '0)
        begin
            // pulse in progress, stalks ignored
            drive = 1'b1;
            prem_dec = state.pulse_remaining - cbi_pkg::PULSE_W'(1);
            s.pulse_remaining = prem_dec;
            if (prem_dec == '0)
            begin
                if (s.blink_count != cbi_pkg::COUNT_TOP)
                    s.blink_count = s.blink_count + cbi_pkg::COUNT_W'(1);
                e = '0;
                do_end_check = 1'b1;
            end
        end
        else
        begin
            if (state.active && elapsed != TIMER_TOP)
                e = elapsed + TIMER_WIDTH'(1);

            // tap starts or restarts a run
            if (any_level && !(state.active && state.heading == dir))
            begin
                s.active      = 1'b1;
                s.heading     = dir;
                e             = '0;
                s.blink_count = cbi_pkg::COUNT_W'(1);
            end

            el_x = CMP_W'(e);
            if (s.active && el_x >= holdoff_x)
            begin
                if (any_level)
                begin
                    // stalk still held: cancel, count kept
                    s.active  = 1'b0;
                    s.heading = cbi_pkg::HEAD_OFF;
                    e         = '0;
                end
                else if (el_x > interval_x)
                begin
                    drive = 1'b1;
                    prem_dec = plen - cbi_pkg::PULSE_W'(1);
                    s.pulse_remaining = prem_dec;
                    if (prem_dec == '0)
                    begin
                        if (s.blink_count != cbi_pkg::COUNT_TOP)
                            s.blink_count = s.blink_count + cbi_pkg::COUNT_W'(1);
                        e = '0;
                        do_end_check = 1'b1;
                    end
                end
                else
                begin
                    do_end_check = 1'b1;
                end
            end
        end

        // drive lines follow the heading at the time of the pulse
        result.drive_left  = drive && (s.heading == cbi_pkg::HEAD_LEFT);
        result.drive_right = drive && (s.heading == cbi_pkg::HEAD_RIGHT);

        if (do_end_check && s.blink_count >= cfg.max_blinks)
        begin
            s.active      = 1'b0;
            s.heading     = cbi_pkg::HEAD_OFF;
            e             = '0;
            s.blink_count = '0;
        end

        result.run_active    = s.active;
        result.run_direction = s.heading;
        result.blinks_done   = s.blink_count;

        state_next   = s;
        elapsed_next = e;
    end

endmodule
